>>> rtl/core/ppsch_pkg.sv
// Shared types and constants of the preemptive priority scheduler.
package ppsch_pkg;

   localparam int MAX_TASKS_DEFAULT = 16;
   localparam int ID_W              = 8;
   localparam int PRIO_W            = 8;
   localparam int TIME_W            = 16;
   localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

   localparam logic ACTION_LOAD = 1'b0;
   localparam logic ACTION_TICK = 1'b1;

   // One row of the task table.
   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [PRIO_W-1:0] prio;
      logic [TIME_W-1:0] arrival;
      logic [TIME_W-1:0] remaining;
      logic [TIME_W-1:0] burst;
   } entry_type;

   // One result word.
   typedef struct packed {
      logic              load_rejected;
      logic              idle;
      logic [ID_W-1:0]   running_id;
      logic              finished;
      logic [TIME_W-1:0] finish_time;
      logic [TIME_W-1:0] turnaround;
      logic [TIME_W-1:0] waiting;
      logic              all_done;
   } rsp_word_type;

endpackage

>>> rtl/core/ppsch_req_if.sv
// Request channel: load or tick words into the scheduler.
interface ppsch_req_if;
   logic                          valid;
   logic                          ready;
   logic                          action;
   logic [ppsch_pkg::ID_W-1:0]    task_id;
   logic [ppsch_pkg::PRIO_W-1:0]  task_priority;
   logic [ppsch_pkg::TIME_W-1:0]  arrival_time;
   logic [ppsch_pkg::TIME_W-1:0]  burst_length;

   modport source (output valid, action, task_id, task_priority, arrival_time,
                   burst_length, input ready);
   modport sink   (input valid, action, task_id, task_priority, arrival_time,
                   burst_length, output ready);
endinterface

>>> rtl/core/ppsch_rsp_if.sv
// Response channel: one result word per request word.
interface ppsch_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         load_rejected;
   logic                         idle;
   logic [ppsch_pkg::ID_W-1:0]   running_id;
   logic                         finished;
   logic [ppsch_pkg::TIME_W-1:0] finish_time;
   logic [ppsch_pkg::TIME_W-1:0] turnaround;
   logic [ppsch_pkg::TIME_W-1:0] waiting;
   logic                         all_done;

   modport source (output valid, load_rejected, idle, running_id, finished,
                   finish_time, turnaround, waiting, all_done, input ready);
   modport sink   (input valid, load_rejected, idle, running_id, finished,
                   finish_time, turnaround, waiting, all_done, output ready);
endinterface

>>> rtl/core/preemptive_priority_scheduler_core.sv
// Preemptive priority scheduler: task table, sequential min-priority scan, completion stats.
//
// A load word passes through accept, table write and result register (states
// IDLE, LOAD, FINISH). A tick word passes through accept, the scan, a drain
// step, evaluation, a waiting step when the served task completes, and the
// result register: the table sits in a single-read-port memory and the scan
// reads one entry per cycle, so the number of loaded entries sets its length. The block takes one word at a
// time; req ready is high only between words. A finished result waits in
// the output register, and the next word is accepted meanwhile; its result
// is held back until the previous one has been taken. Memory contents need
// no clearing after reset: only entries below the fill count are ever read.
module preemptive_priority_scheduler_core #(
   parameter int MAX_TASKS = ppsch_pkg::MAX_TASKS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   ppsch_req_if.sink   req_port,
   ppsch_rsp_if.source rsp_port
);

   localparam int CNT_W = $clog2(MAX_TASKS + 1);
   localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_TASKS);

   // sequencer codes
   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_LOAD   = 3'd1;
   localparam logic [2:0] ST_SCAN   = 3'd2;
   localparam logic [2:0] ST_DRAIN  = 3'd3;
   localparam logic [2:0] ST_EVAL   = 3'd4;
   localparam logic [2:0] ST_WAIT   = 3'd5;
   localparam logic [2:0] ST_FINISH = 3'd6;

   localparam int TW = ppsch_pkg::TIME_W;

   // ---------------------------------------------------------------------
   // State
   // ---------------------------------------------------------------------
   logic [2:0]                 state_ff, state_in;
   logic [CNT_W-1:0]           entry_count_ff, entry_count_in;
   logic [CNT_W-1:0]           finished_count_ff, finished_count_in;
   logic [TW-1:0]              current_time_ff, current_time_in;
   logic [MAX_TASKS-1:0]       done_flags_ff, done_flags_in;

   // captured request word and the tick's next time
   ppsch_pkg::entry_type       req_word_ff, req_word_in;
   logic [TW-1:0]              next_time_ff, next_time_in;

   // scan
   logic [CNT_W-1:0]           scan_idx_ff, scan_idx_in;
   logic                       rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0]           rd_idx_ff;
   ppsch_pkg::entry_type       rd_word_ff;
   logic                       best_vld_ff, best_vld_in;
   logic [IDX_W-1:0]           best_idx_ff, best_idx_in;
   ppsch_pkg::entry_type       best_word_ff, best_word_in;

   // result staging and output register
   ppsch_pkg::rsp_word_type    res_ff, res_in;
   ppsch_pkg::rsp_word_type    rsp_word_ff, rsp_word_in;
   logic                       rsp_valid_ff, rsp_valid_in;

   // task table
   ppsch_pkg::entry_type       table_mem [MAX_TASKS];
   logic                       mem_we;
   logic [IDX_W-1:0]           mem_waddr;
   ppsch_pkg::entry_type       mem_wdata;
   logic                       rd_en;

   // shared subtractor: turnaround, then waiting
   logic [TW-1:0]              alu_a, alu_b;
   logic [TW:0]                alu_diff;

   logic                       req_fire;
   logic                       cand_hit;

   assign req_port.ready = (state_ff == ST_IDLE);
   assign req_fire       = req_port.valid && req_port.ready;

   assign rsp_port.valid         = rsp_valid_ff;
   assign rsp_port.load_rejected = rsp_word_ff.load_rejected;
   assign rsp_port.idle          = rsp_word_ff.idle;
   assign rsp_port.running_id    = rsp_word_ff.running_id;
   assign rsp_port.finished      = rsp_word_ff.finished;
   assign rsp_port.finish_time   = rsp_word_ff.finish_time;
   assign rsp_port.turnaround    = rsp_word_ff.turnaround;
   assign rsp_port.waiting       = rsp_word_ff.waiting;
   assign rsp_port.all_done      = rsp_word_ff.all_done;

   assign alu_a    = (state_ff == ST_WAIT) ? res_ff.turnaround : next_time_ff;
   assign alu_b    = (state_ff == ST_WAIT) ? best_word_ff.burst : best_word_ff.arrival;
   assign alu_diff = {1'b0, alu_a} - {1'b0, alu_b};

   // candidate test on the word read last cycle
   assign cand_hit = rd_vld_ff && !done_flags_ff[rd_idx_ff]
                     && (rd_word_ff.arrival <= current_time_ff)
                     && (!best_vld_ff || (rd_word_ff.prio < best_word_ff.prio));

   assign rd_en     = (state_ff == ST_SCAN) && (scan_idx_ff != entry_count_ff);
   assign rd_vld_in = rd_en;

   always_comb begin
      state_in          = state_ff;
      entry_count_in    = entry_count_ff;
      finished_count_in = finished_count_ff;
      current_time_in   = current_time_ff;
      done_flags_in     = done_flags_ff;
      req_word_in       = req_word_ff;
      next_time_in      = next_time_ff;
      scan_idx_in       = scan_idx_ff;
      best_vld_in       = best_vld_ff;
      best_idx_in       = best_idx_ff;
      best_word_in      = best_word_ff;
      res_in            = res_ff;
      rsp_word_in       = rsp_word_ff;
      rsp_valid_in      = rsp_valid_ff && !rsp_port.ready;
      mem_we            = 1'b0;
      mem_waddr         = entry_count_ff[IDX_W-1:0];
      mem_wdata         = req_word_ff;

      if (cand_hit) begin
         best_vld_in  = 1'b1;
         best_idx_in  = rd_idx_ff;
         best_word_in = rd_word_ff;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               req_word_in.id        = req_port.task_id;
               req_word_in.prio      = req_port.task_priority;
               req_word_in.arrival   = req_port.arrival_time;
               req_word_in.remaining = req_port.burst_length;
               req_word_in.burst     = req_port.burst_length;
               res_in       = '0;
               scan_idx_in  = '0;
               best_vld_in  = 1'b0;
               next_time_in = (current_time_ff == ppsch_pkg::TIME_MAX)
                              ? ppsch_pkg::TIME_MAX : current_time_ff + TW'(1);
               state_in     = (req_port.action == ppsch_pkg::ACTION_TICK)
                              ? ST_SCAN : ST_LOAD;
            end
         end
         ST_LOAD: begin
            if (entry_count_ff == CNT_MAX) begin
               res_in.load_rejected = 1'b1;
            end else begin
               mem_we         = 1'b1;
               done_flags_in[entry_count_ff[IDX_W-1:0]] = 1'b0;
               entry_count_in = entry_count_ff + CNT_W'(1);
            end
            state_in = ST_FINISH;
         end
         ST_SCAN: begin
            if (scan_idx_ff == entry_count_ff) begin
               state_in = ST_DRAIN;
            end else begin
               scan_idx_in = scan_idx_ff + CNT_W'(1);
            end
         end
         ST_DRAIN: begin
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            current_time_in = next_time_ff;
            if (!best_vld_ff) begin
               res_in.idle = 1'b1;
               state_in    = ST_FINISH;
            end else begin
               res_in.running_id = best_word_ff.id;
               mem_we    = 1'b1;
               mem_waddr = best_idx_ff;
               mem_wdata = best_word_ff;
               if (best_word_ff.remaining <= TW'(1)) begin
                  mem_wdata.remaining        = '0;
                  done_flags_in[best_idx_ff] = 1'b1;
                  finished_count_in  = finished_count_ff + CNT_W'(1);
                  res_in.finished    = 1'b1;
                  res_in.finish_time = next_time_ff;
                  res_in.turnaround  = alu_diff[TW-1:0];
                  state_in           = ST_WAIT;
               end else begin
                  mem_wdata.remaining = best_word_ff.remaining - TW'(1);
                  state_in            = ST_FINISH;
               end
            end
         end
         ST_WAIT: begin
            // borrow means turnaround below burst: clamp at zero
            res_in.waiting = alu_diff[TW] ? '0 : alu_diff[TW-1:0];
            state_in       = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_port.ready) begin
               rsp_word_in          = res_ff;
               rsp_word_in.all_done = (finished_count_ff == entry_count_ff);
               rsp_valid_in         = 1'b1;
               state_in             = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_IDLE;
         entry_count_ff    <= '0;
         finished_count_ff <= '0;
         current_time_ff   <= '0;
         done_flags_ff     <= '0;
         rsp_valid_ff      <= 1'b0;
         rd_vld_ff         <= 1'b0;
         best_vld_ff       <= 1'b0;
      end else begin
         state_ff          <= state_in;
         entry_count_ff    <= entry_count_in;
         finished_count_ff <= finished_count_in;
         current_time_ff   <= current_time_in;
         done_flags_ff     <= done_flags_in;
         rsp_valid_ff      <= rsp_valid_in;
         rd_vld_ff         <= rd_vld_in;
         best_vld_ff       <= best_vld_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      req_word_ff  <= req_word_in;
      next_time_ff <= next_time_in;
      scan_idx_ff  <= scan_idx_in;
      best_idx_ff  <= best_idx_in;
      best_word_ff <= best_word_in;
      res_ff       <= res_in;
      rsp_word_ff  <= rsp_word_in;
      rd_idx_ff    <= scan_idx_ff[IDX_W-1:0];
   end

   // task table: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         table_mem[mem_waddr] <= mem_wdata;
      end
      if (rd_en) begin
         rd_word_ff <= table_mem[scan_idx_ff[IDX_W-1:0]];
      end
   end

endmodule

>>> rtl/core/ppsch_checker.sv
// Port-level checks of the scheduler and their binding to the top level.
module ppsch_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic                         load_rejected,
   input logic                         idle,
   input logic [ppsch_pkg::ID_W-1:0]   running_id,
   input logic                         finished,
   input logic [ppsch_pkg::TIME_W-1:0] finish_time,
   input logic [ppsch_pkg::TIME_W-1:0] turnaround,
   input logic [ppsch_pkg::TIME_W-1:0] waiting
);

   // stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(running_id)
      && $stable(finish_time) && $stable(turnaround) && $stable(waiting))
      else $error("result word changed while stalled");

   // no result straight out of reset
   a_rsp_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // a rejected load or idle tick reports no service
   a_no_service: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (load_rejected || idle) |-> !finished && running_id == '0
      && finish_time == '0 && !(load_rejected && idle))
      else $error("service fields set on a word without service");

   // waiting never exceeds turnaround
   a_wait_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && finished |-> waiting <= turnaround)
      else $error("waiting above turnaround");

endmodule

bind preemptive_priority_scheduler_core ppsch_checker u_ppsch_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_port.valid),
   .rsp_ready     (rsp_port.ready),
   .load_rejected (rsp_port.load_rejected),
   .idle          (rsp_port.idle),
   .running_id    (rsp_port.running_id),
   .finished      (rsp_port.finished),
   .finish_time   (rsp_port.finish_time),
   .turnaround    (rsp_port.turnaround),
   .waiting       (rsp_port.waiting)
);
